@@ rtl/scfd_pkg.sv @@
// Package for the SIO command frame detector: fixed sizes, register indexes
// and the end-around-carry adder. No dependencies.
`default_nettype none

package scfd_pkg;

    localparam int unsigned BYTE_W    = 8;
    localparam int unsigned WIN_LEN   = 4;
    localparam int unsigned FILL_W    = 3;
    localparam int unsigned IDS_W     = 64;
    localparam int unsigned COUNT_W   = 4;
    localparam int unsigned CFG_IDX_W = 2;
    localparam int unsigned CFG_DATA_W = 64;

    localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE_IDS   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE_COUNT = 2'd1;

    typedef logic [BYTE_W-1:0] byte_t;

    // One step of the ones'-complement style sum: add, and fold a carry back
    // in (subtracting 255 equals dropping 256 and adding one).
    function automatic byte_t eac_add(input byte_t a, input byte_t b);
        logic [BYTE_W:0] s;
        begin
            s = {1'b0, a} + {1'b0, b};
            if (s[BYTE_W])
            begin
                eac_add = s[BYTE_W-1:0] + byte_t'(1);
            end
            else
            begin
                eac_add = s[BYTE_W-1:0];
            end
        end
    endfunction

endpackage

`default_nettype wire

@@ rtl/sio_command_frame_detector.sv @@
// SIO command frame detector, top level: byte window, device and checksum
// check, result register. Depends on scfd_pkg.
`default_nettype none

// Channel   | Signals                                         | Dir | Beat
// ----------+-------------------------------------------------+-----+---------------------
// rx        | rx_valid, rx_ready, rx_byte                     | in  | one serial byte
// frame     | frame_valid, frame_ready, frame_device,         | out | one detected frame
//           | command_code, aux_first, aux_second             |     |
// cfg       | cfg_valid, cfg_ready, cfg_index, cfg_data       | in  | one register write
//
// A byte beat lands in an input register. From there the window check and
// update run and a completed frame is loaded into the result register, which
// drives frame_valid. One byte is taken every cycle; the input stalls only
// while a frame waits in the result register and the held byte would complete
// another one. rst_n clears the valid flags, the fill level and the
// configuration; window bytes are rewritten before they are read.

module sio_command_frame_detector #(
    parameter int unsigned MAX_DEVICES = 8
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,

    input  wire logic                              rx_valid,
    output logic                                   rx_ready,
    input  wire logic [scfd_pkg::BYTE_W-1:0]       rx_byte,

    output logic                                   frame_valid,
    input  wire logic                              frame_ready,
    output logic [scfd_pkg::BYTE_W-1:0]            frame_device,
    output logic [scfd_pkg::BYTE_W-1:0]            command_code,
    output logic [scfd_pkg::BYTE_W-1:0]            aux_first,
    output logic [scfd_pkg::BYTE_W-1:0]            aux_second,

    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic [scfd_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [scfd_pkg::CFG_DATA_W-1:0]   cfg_data
);

    localparam int unsigned SLOTS = scfd_pkg::IDS_W / scfd_pkg::BYTE_W;
    localparam int unsigned SLOT_LIMIT = (MAX_DEVICES < SLOTS) ? MAX_DEVICES : SLOTS;

    // Configuration registers.
    logic [scfd_pkg::IDS_W-1:0]   active_ids_reg;
    logic [scfd_pkg::COUNT_W-1:0] active_count_reg;

    // Input stage.
    logic            in_valid_reg;
    scfd_pkg::byte_t in_byte_reg;

    // Window state; entry 0 is the oldest byte.
    scfd_pkg::byte_t               window_reg [scfd_pkg::WIN_LEN];
    scfd_pkg::byte_t               window_next [scfd_pkg::WIN_LEN];
    logic [scfd_pkg::FILL_W-1:0]   fill_reg;
    logic [scfd_pkg::FILL_W-1:0]   fill_next;

    // Result register.
    logic            out_valid_reg;
    scfd_pkg::byte_t out_bytes_reg [scfd_pkg::WIN_LEN];

    logic                          full;
    logic                          id_hit;
    logic                          hit;
    logic                          advance;
    logic [scfd_pkg::COUNT_W-1:0]  eff_count;
    scfd_pkg::byte_t               checksum;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_ids_reg   <= '0;
            active_count_reg <= '0;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                scfd_pkg::CFG_ACTIVE_IDS:   active_ids_reg   <= cfg_data;
                scfd_pkg::CFG_ACTIVE_COUNT: active_count_reg <= cfg_data[scfd_pkg::COUNT_W-1:0];
                default:                    ;
            endcase
        end
    end

    // A count beyond the number of slots the design carries saturates.
    always_comb
    begin
        if (active_count_reg > scfd_pkg::COUNT_W'(SLOT_LIMIT))
        begin
            eff_count = scfd_pkg::COUNT_W'(SLOT_LIMIT);
        end
        else
        begin
            eff_count = active_count_reg;
        end
    end

    // The oldest byte is compared with every enabled slot in parallel.
    always_comb
    begin
        id_hit = 1'b0;
        for (int i = 0; i < SLOT_LIMIT; i++)
        begin
            if ((scfd_pkg::COUNT_W'(i) < eff_count) &&
                (active_ids_reg[i*scfd_pkg::BYTE_W +: scfd_pkg::BYTE_W] == window_reg[0]))
            begin
                id_hit = 1'b1;
            end
        end
    end

    // Checksum over the four held bytes, folded after every addition.
    always_comb
    begin
        checksum = window_reg[0];
        for (int i = 1; i < scfd_pkg::WIN_LEN; i++)
        begin
            checksum = scfd_pkg::eac_add(checksum, window_reg[i]);
        end
    end

    assign full    = (fill_reg == scfd_pkg::FILL_W'(scfd_pkg::WIN_LEN));
    assign hit     = full && id_hit && (checksum == in_byte_reg);
    // A byte that completes no frame never needs the result register.
    assign advance = in_valid_reg && (!out_valid_reg || frame_ready || !hit);
    assign rx_ready = !in_valid_reg || advance;

    always_comb
    begin
        window_next = window_reg;
        fill_next   = fill_reg;
        if (!full)
        begin
            window_next[fill_reg[1:0]] = in_byte_reg;
            fill_next = fill_reg + scfd_pkg::FILL_W'(1);
        end
        else if (hit)
        begin
            fill_next = '0;
        end
        else
        begin
            for (int i = 0; i + 1 < scfd_pkg::WIN_LEN; i++)
            begin
                window_next[i] = window_reg[i+1];
            end
            window_next[scfd_pkg::WIN_LEN-1] = in_byte_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            fill_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (rx_ready)
            begin
                in_valid_reg <= rx_valid;
            end
            if (advance)
            begin
                fill_reg <= fill_next;
            end
            if (advance && hit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (frame_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (rx_valid && rx_ready)
        begin
            in_byte_reg <= rx_byte;
        end
        if (advance)
        begin
            window_reg <= window_next;
        end
        if (advance && hit)
        begin
            out_bytes_reg <= window_reg;
        end
    end

    assign frame_valid  = out_valid_reg;
    assign frame_device = out_bytes_reg[0];
    assign command_code = out_bytes_reg[1];
    assign aux_first    = out_bytes_reg[2];
    assign aux_second   = out_bytes_reg[3];

endmodule

`default_nettype wire

@@ rtl/scfd_checker.sv @@
// Port-level checks for the SIO command frame detector, and the bind that
// attaches them to the top level. Depends on scfd_pkg.
`default_nettype none

module scfd_checker (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              rx_ready,
    input  wire logic                              frame_valid,
    input  wire logic                              frame_ready,
    input  wire logic [scfd_pkg::BYTE_W-1:0]       frame_device,
    input  wire logic [scfd_pkg::BYTE_W-1:0]       command_code,
    input  wire logic [scfd_pkg::BYTE_W-1:0]       aux_first,
    input  wire logic [scfd_pkg::BYTE_W-1:0]       aux_second,
    input  wire logic                              cfg_ready
);

    // No frame is offered while reset is held.
    assert property (@(posedge clk) !rst_n |-> !frame_valid)
        else $error("frame offered during reset");

    // A waiting frame keeps valid and its bytes until it is taken.
    assert property (@(posedge clk) disable iff (!rst_n)
        frame_valid && !frame_ready |=> frame_valid && $stable(frame_device) &&
            $stable(command_code) && $stable(aux_first) && $stable(aux_second))
        else $error("waiting frame dropped or changed");

    // The byte input only stalls behind a frame that is blocked downstream.
    assert property (@(posedge clk) disable iff (!rst_n)
        !rx_ready |-> frame_valid && !frame_ready)
        else $error("byte input stalled without output back-pressure");

    // Register writes are never held off.
    assert property (@(posedge clk) disable iff (!rst_n) cfg_ready)
        else $error("configuration port not ready");

endmodule

bind sio_command_frame_detector scfd_checker u_scfd_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .rx_ready     (rx_ready),
    .frame_valid  (frame_valid),
    .frame_ready  (frame_ready),
    .frame_device (frame_device),
    .command_code (command_code),
    .aux_first    (aux_first),
    .aux_second   (aux_second),
    .cfg_ready    (cfg_ready)
);

`default_nettype wire
